[rtl/core/char_lcd_nibble_write_sequencer_defines.svh]
// Assertion macros shared by the checker of the character LCD write sequencer.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH

// The consequent must hold on the same edge as the antecedent.
`define CLNWS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("clnws assertion failed");

// The consequent must hold on the edge after the antecedent.
`define CLNWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("clnws assertion failed");

`endif

[rtl/core/clnws_pkg.sv]
// Shared types, constants and wait arithmetic of the character LCD write sequencer.
`default_nettype none
package clnws_pkg;

    localparam int WAIT_COUNTER_BITS = 24;
    localparam int US_BITS           = 14;
    localparam int TPU_BITS          = 7;
    localparam int PROD_BITS         = US_BITS + TPU_BITS;
    localparam int CMP_BITS          = (WAIT_COUNTER_BITS > PROD_BITS) ?
                                       WAIT_COUNTER_BITS : PROD_BITS;

    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_CMD   = 3'd1;
    localparam logic [2:0] OP_DATA  = 3'd2;
    localparam logic [2:0] OP_INIT  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;
    localparam logic [2:0] OP_HOME  = 3'd5;

    localparam logic [1:0] CFG_TICKS_PER_US = 2'd0;
    localparam logic [1:0] CFG_ENABLE_WIDTH = 2'd1;

    localparam logic [US_BITS-1:0] US_POWER_UP  = 14'd15000;
    localparam logic [US_BITS-1:0] US_INIT_A    = 14'd4100;
    localparam logic [US_BITS-1:0] US_INIT_B    = 14'd200;
    localparam logic [US_BITS-1:0] US_BYTE      = 14'd120;
    localparam logic [US_BITS-1:0] US_LONG      = 14'd4800;

    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0E;
    localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [3:0] NIB_WAKE      = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT  = 4'h2;

    typedef enum logic [2:0] {
        REQ_NONE,
        REQ_CMD,
        REQ_DATA,
        REQ_INIT,
        REQ_CLEAR,
        REQ_HOME
    } t_req;

    typedef struct packed {
        t_req       kind;
        logic [7:0] byte_value;
    } t_qent;

    function automatic logic [WAIT_COUNTER_BITS-1:0] f_wait_ticks(
        input logic [US_BITS-1:0]  us,
        input logic [TPU_BITS-1:0] tpu
    );
        logic [PROD_BITS-1:0]         prod;
        logic [CMP_BITS-1:0]          wide;
        logic [CMP_BITS-1:0]          lim;
        logic [WAIT_COUNTER_BITS-1:0] res;
        prod = PROD_BITS'(us) * PROD_BITS'(tpu);
        wide = CMP_BITS'(prod);
        lim  = CMP_BITS'({WAIT_COUNTER_BITS{1'b1}});
        if (wide > lim) begin
            res = '1;
        end else begin
            res = WAIT_COUNTER_BITS'(wide);
        end
        if (res == '0) begin
            res = WAIT_COUNTER_BITS'(1);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[rtl/core/clnws_front.sv]
// Front end: takes input items, classifies the op and queues them for the sequencer.
`default_nettype none
module clnws_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_tvalid,
    output logic                  o_tready,
    input  wire logic [2:0]       i_op,
    input  wire logic [7:0]       i_byte_value,
    output logic                  o_q_valid,
    input  wire logic             i_q_ready,
    output clnws_pkg::t_qent      o_q_ent
);

    clnws_pkg::t_qent                     r_mem [clnws_pkg::Q_DEPTH];
    logic [clnws_pkg::Q_PTR_BITS-1:0]     r_wptr;
    logic [clnws_pkg::Q_PTR_BITS-1:0]     r_rptr;
    logic [clnws_pkg::Q_CNT_BITS-1:0]     r_count;
    logic [clnws_pkg::Q_PTR_BITS-1:0]     n_wptr;
    logic [clnws_pkg::Q_PTR_BITS-1:0]     n_rptr;
    logic [clnws_pkg::Q_CNT_BITS-1:0]     n_count;
    logic                                 push;
    logic                                 pop;
    clnws_pkg::t_qent                     ent_in;

    function automatic clnws_pkg::t_req f_classify(input logic [2:0] op);
        clnws_pkg::t_req k;
        case (op)
            clnws_pkg::OP_CMD:   k = clnws_pkg::REQ_CMD;
            clnws_pkg::OP_DATA:  k = clnws_pkg::REQ_DATA;
            clnws_pkg::OP_INIT:  k = clnws_pkg::REQ_INIT;
            clnws_pkg::OP_CLEAR: k = clnws_pkg::REQ_CLEAR;
            clnws_pkg::OP_HOME:  k = clnws_pkg::REQ_HOME;
            default:             k = clnws_pkg::REQ_NONE;
        endcase
        return k;
    endfunction

    assign o_tready  = (r_count != clnws_pkg::Q_CNT_BITS'(clnws_pkg::Q_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_ent   = r_mem[r_rptr];
    assign push      = i_tvalid && o_tready;
    assign pop       = o_q_valid && i_q_ready;

    always_comb begin
        ent_in.kind       = f_classify(i_op);
        ent_in.byte_value = i_byte_value;
        n_wptr  = push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= ent_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

[rtl/core/clnws_back.sv]
// Back end: runs the pin sequencer one tick per queued item and registers the result.
`default_nettype none
module clnws_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    output logic                  o_q_ready,
    input  clnws_pkg::t_qent      i_q_ent,
    input  wire logic             i_cfg_valid,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [7:0]       i_cfg_data,
    output logic                  o_tvalid,
    input  wire logic             i_tready,
    output logic [7:0]            o_tdata
);

    localparam int WB = clnws_pkg::WAIT_COUNTER_BITS;

    localparam logic [3:0] STEP_NONE       = 4'd0;
    localparam logic [3:0] STEP_POWER_WAIT = 4'd1;
    localparam logic [3:0] STEP_NIB_A      = 4'd2;
    localparam logic [3:0] STEP_NIB_B      = 4'd3;
    localparam logic [3:0] STEP_NIB_C      = 4'd4;
    localparam logic [3:0] STEP_FUNC       = 4'd5;
    localparam logic [3:0] STEP_OFF        = 4'd6;
    localparam logic [3:0] STEP_CLEAR      = 4'd7;
    localparam logic [3:0] STEP_ENTRY      = 4'd8;
    localparam logic [3:0] STEP_ON         = 4'd9;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HI_ON,
        PH_HI_OFF,
        PH_LO_ON,
        PH_LO_OFF,
        PH_WAIT
    } t_phase;

    typedef struct packed {
        t_phase          phase;
        logic [WB-1:0]   wait_count;
        logic [7:0]      held;
        logic [3:0]      step;
        logic            long_pend;
        logic            rs;
        logic            en;
        logic [3:0]      nib;
    } t_seq;

    t_seq                              r_seq;
    t_seq                              n_seq;
    t_seq                              a_seq;
    logic [clnws_pkg::TPU_BITS-1:0]    r_tpu;
    logic [7:0]                        r_enw;
    logic                              r_out_valid;
    logic [7:0]                        r_out_data;
    logic                              pop;
    logic                              req;
    logic                              rej;
    logic                              active;
    logic [WB-1:0]                     en_t;
    logic [WB-1:0]                     dec;
    logic [WB-1:0]                     wt_power;
    logic [WB-1:0]                     wt_fin;
    logic [clnws_pkg::US_BITS-1:0]     fin_us;
    logic [3:0]                        nstep;

    function automatic t_seq f_byte(input t_seq s, input logic rs, input logic [7:0] b,
                                    input logic lw, input logic [WB-1:0] et);
        t_seq r;
        r            = s;
        r.held       = b;
        r.long_pend  = lw;
        r.rs         = rs;
        r.en         = 1'b1;
        r.nib        = b[7:4];
        r.phase      = PH_HI_ON;
        r.wait_count = et;
        return r;
    endfunction

    function automatic t_seq f_nib(input t_seq s, input logic [3:0] n,
                                   input logic [WB-1:0] et);
        t_seq r;
        r            = s;
        r.held       = {4'd0, n};
        r.long_pend  = 1'b0;
        r.rs         = 1'b0;
        r.en         = 1'b1;
        r.nib        = n;
        r.phase      = PH_LO_ON;
        r.wait_count = et;
        return r;
    endfunction

    assign o_q_ready = !r_out_valid || i_tready;
    assign pop       = i_q_valid && o_q_ready;
    assign o_tvalid  = r_out_valid;
    assign o_tdata   = r_out_data;

    always_comb begin
        en_t     = (r_enw == '0) ? WB'(1) : WB'(r_enw);
        wt_power = clnws_pkg::f_wait_ticks(clnws_pkg::US_POWER_UP, r_tpu);
        req      = (i_q_ent.kind != clnws_pkg::REQ_NONE);
        rej      = (r_seq.phase != PH_IDLE) && req;

        a_seq = r_seq;
        if (r_seq.phase == PH_IDLE && req) begin
            a_seq.step = STEP_NONE;
            case (i_q_ent.kind)
                clnws_pkg::REQ_CMD:
                    a_seq = f_byte(a_seq, 1'b0, i_q_ent.byte_value, 1'b0, en_t);
                clnws_pkg::REQ_DATA:
                    a_seq = f_byte(a_seq, 1'b1, i_q_ent.byte_value, 1'b0, en_t);
                clnws_pkg::REQ_INIT: begin
                    a_seq.step       = STEP_POWER_WAIT;
                    a_seq.en         = 1'b0;
                    a_seq.phase      = PH_WAIT;
                    a_seq.wait_count = wt_power;
                end
                clnws_pkg::REQ_CLEAR:
                    a_seq = f_byte(a_seq, 1'b0, clnws_pkg::CMD_CLEAR, 1'b1, en_t);
                clnws_pkg::REQ_HOME:
                    a_seq = f_byte(a_seq, 1'b0, clnws_pkg::CMD_HOME, 1'b1, en_t);
                default: a_seq = r_seq;
            endcase
        end
        active = (a_seq.phase != PH_IDLE);

        if (a_seq.phase == PH_WAIT) begin
            fin_us = clnws_pkg::US_LONG;
        end else if (a_seq.step == STEP_NIB_A) begin
            fin_us = clnws_pkg::US_INIT_A;
        end else if (a_seq.step == STEP_NIB_B || a_seq.step == STEP_NIB_C) begin
            fin_us = clnws_pkg::US_INIT_B;
        end else begin
            fin_us = clnws_pkg::US_BYTE;
        end
        wt_fin = clnws_pkg::f_wait_ticks(fin_us, r_tpu);

        dec   = (a_seq.wait_count != '0) ? a_seq.wait_count - 1'b1 : a_seq.wait_count;
        nstep = a_seq.step + 4'd1;
        n_seq = a_seq;
        if (active) begin
            n_seq.wait_count = dec;
            if (dec == '0) begin
                case (a_seq.phase)
                    PH_HI_ON: begin
                        n_seq.en         = 1'b0;
                        n_seq.phase      = PH_HI_OFF;
                        n_seq.wait_count = en_t;
                    end
                    PH_HI_OFF: begin
                        n_seq.en         = 1'b1;
                        n_seq.nib        = a_seq.held[3:0];
                        n_seq.phase      = PH_LO_ON;
                        n_seq.wait_count = en_t;
                    end
                    PH_LO_ON: begin
                        n_seq.en         = 1'b0;
                        n_seq.phase      = PH_LO_OFF;
                        n_seq.wait_count = en_t;
                    end
                    PH_LO_OFF: begin
                        n_seq.en         = 1'b0;
                        n_seq.phase      = PH_WAIT;
                        n_seq.wait_count = wt_fin;
                    end
                    PH_WAIT: begin
                        if (a_seq.long_pend) begin
                            n_seq.long_pend  = 1'b0;
                            n_seq.en         = 1'b0;
                            n_seq.phase      = PH_WAIT;
                            n_seq.wait_count = wt_fin;
                        end else if (a_seq.step >= STEP_POWER_WAIT && a_seq.step < STEP_ON) begin
                            n_seq.step = nstep;
                            case (nstep)
                                STEP_NIB_A: n_seq = f_nib(n_seq, clnws_pkg::NIB_WAKE, en_t);
                                STEP_NIB_B: n_seq = f_nib(n_seq, clnws_pkg::NIB_WAKE, en_t);
                                STEP_NIB_C: n_seq = f_nib(n_seq, clnws_pkg::NIB_FOUR_BIT, en_t);
                                STEP_FUNC:
                                    n_seq = f_byte(n_seq, 1'b0, clnws_pkg::CMD_FUNC_SET,
                                                   1'b0, en_t);
                                STEP_OFF:
                                    n_seq = f_byte(n_seq, 1'b0, clnws_pkg::CMD_DISP_OFF,
                                                   1'b0, en_t);
                                STEP_CLEAR:
                                    n_seq = f_byte(n_seq, 1'b0, clnws_pkg::CMD_CLEAR,
                                                   1'b1, en_t);
                                STEP_ENTRY:
                                    n_seq = f_byte(n_seq, 1'b0, clnws_pkg::CMD_ENTRY,
                                                   1'b0, en_t);
                                STEP_ON:
                                    n_seq = f_byte(n_seq, 1'b0, clnws_pkg::CMD_DISP_ON,
                                                   1'b0, en_t);
                                default: begin
                                    n_seq.step       = STEP_NONE;
                                    n_seq.phase      = PH_IDLE;
                                    n_seq.wait_count = '0;
                                end
                            endcase
                        end else begin
                            n_seq.step       = STEP_NONE;
                            n_seq.phase      = PH_IDLE;
                            n_seq.wait_count = '0;
                        end
                    end
                    default: begin
                        n_seq.step       = STEP_NONE;
                        n_seq.phase      = PH_IDLE;
                        n_seq.wait_count = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq.phase      <= PH_IDLE;
            r_seq.wait_count <= '0;
            r_seq.held       <= '0;
            r_seq.step       <= STEP_NONE;
            r_seq.long_pend  <= 1'b0;
            r_seq.rs         <= 1'b0;
            r_seq.en         <= 1'b0;
            r_seq.nib        <= '0;
            r_tpu            <= clnws_pkg::TPU_BITS'(4);
            r_enw            <= 8'd1;
            r_out_valid      <= 1'b0;
            r_out_data       <= '0;
        end else begin
            if (pop) begin
                r_seq      <= n_seq;
                r_out_data <= {rej, active, a_seq.nib, a_seq.en, a_seq.rs};
            end
            if (o_q_ready) begin
                r_out_valid <= i_q_valid;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    clnws_pkg::CFG_TICKS_PER_US: r_tpu <= i_cfg_data[clnws_pkg::TPU_BITS-1:0];
                    clnws_pkg::CFG_ENABLE_WIDTH: r_enw <= i_cfg_data;
                    default: r_enw <= r_enw;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

[rtl/core/char_lcd_nibble_write_sequencer.sv]
// Top level of the 4-bit character LCD write sequencer.
//
//   channel   direction   payload
//   i_s_*     in          op, byte_value
//   o_m_*     out         reg_select, enable, bus_nibble, busy_res, rejected
//   i_cfg_*   in          index 0 ticks_per_us, index 1 enable_width
//
// Each input item is one sequencer tick and yields one output item; one item per cycle
// while the output is not stalled. An item passes through the input queue and then the
// output register. Each sequencer step is computed combinationally and registered.
// Reset is synchronous and returns all pins low, the sequencer idle and the registers
// to ticks_per_us 4 and enable_width 1. An output stall backs up into the queue and then
// drops o_s_tready; configuration writes are always taken.
`default_nettype none
module char_lcd_nibble_write_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [2:0] op, [10:3] byte_value, [15:11] zero
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // [0] reg_select, [1] enable, [5:2] bus_nibble,
                                          // [6] busy_res, [7] rejected
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    logic             q_valid;
    logic             q_ready;
    clnws_pkg::t_qent q_ent;

    assign o_cfg_ready = 1'b1;

    clnws_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tvalid     (i_s_tvalid),
        .o_tready     (o_s_tready),
        .i_op         (i_s_tdata[2:0]),
        .i_byte_value (i_s_tdata[10:3]),
        .o_q_valid    (q_valid),
        .i_q_ready    (q_ready),
        .o_q_ent      (q_ent)
    );

    clnws_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_ent     (q_ent),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_tvalid    (o_m_tvalid),
        .i_tready    (i_m_tready),
        .o_tdata     (o_m_tdata)
    );

endmodule
`default_nettype wire

[rtl/core/clnws_checker.sv]
// Port-level checker of the character LCD write sequencer and its bind.
`default_nettype none
`include "char_lcd_nibble_write_sequencer_defines.svh"
module clnws_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [7:0]  o_m_tdata
);

    `CLNWS_ASSERT_SAME(a_rej_needs_busy, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[7], o_m_tdata[6])
    `CLNWS_ASSERT_SAME(a_strobe_needs_busy, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[1], o_m_tdata[6])
    `CLNWS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

endmodule

bind char_lcd_nibble_write_sequencer clnws_checker u_clnws_checker (.*);
`default_nettype wire

[tb/char_lcd_nibble_write_sequencer_tb.sv]
// Self-checking testbench for the 4-bit character LCD write sequencer, with an item-accurate pin predictor.
module char_lcd_nibble_write_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam logic [1:0] CFG_UNUSED_2 = 2'd2;
    localparam logic [1:0] CFG_UNUSED_3 = 2'd3;

    localparam int unsigned WAIT_POWER_UP_US = 15000;
    localparam int unsigned WAIT_WAKE_FIRST_US = 4100;
    localparam int unsigned WAIT_WAKE_NEXT_US = 200;
    localparam int unsigned WAIT_BYTE_US = 120;
    localparam int unsigned WAIT_LONG_US = 4800;
    localparam longint unsigned WAIT_MAX = (64'd1 << clnws_pkg::WAIT_COUNTER_BITS) - 1;

    localparam logic [7:0] LCD_FUNC_4BIT = 8'h28;
    localparam logic [7:0] LCD_DISPLAY_OFF = 8'h08;
    localparam logic [7:0] LCD_CLEAR = 8'h01;
    localparam logic [7:0] LCD_HOME = 8'h02;
    localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] LCD_DISPLAY_ON = 8'h0E;
    localparam logic [3:0] NIBBLE_WAKE = 4'h3;
    localparam logic [3:0] NIBBLE_4BIT = 4'h2;

    localparam int STEP_POWER_WAIT = 1;
    localparam int STEP_WAKE_1 = 2;
    localparam int STEP_WAKE_2 = 3;
    localparam int STEP_FOUR_BIT = 4;
    localparam int STEP_FUNC_SET = 5;
    localparam int STEP_DISPLAY_OFF = 6;
    localparam int STEP_CLEAR = 7;
    localparam int STEP_ENTRY = 8;
    localparam int STEP_DISPLAY_ON = 9;

    localparam int RANDOM_BLOCKS = 4;
    localparam int RANDOM_BLOCK_ITEMS = 100;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_HI_ON,
        SEQ_HI_OFF,
        SEQ_LO_ON,
        SEQ_LO_OFF,
        SEQ_WAIT
    } t_seq_phase;

    typedef struct packed {
        logic       rejected;
        logic       busy;
        logic [3:0] bus;
        logic       e;
        logic       rs;
    } t_lcd_pins;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    char_lcd_nibble_write_sequencer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    logic [6:0]  tpu_reg = 7'd4;
    logic [7:0]  ew_reg = 8'd1;
    t_seq_phase  seq_state = SEQ_IDLE;
    int unsigned wait_left = 0;
    logic [7:0]  held_byte = 8'h00;
    int          init_idx = 0;
    logic        long_pending = 1'b0;
    logic        pin_rs = 1'b0;
    logic        pin_e = 1'b0;
    logic [3:0]  pin_bus = 4'h0;

    t_lcd_pins   expected_pins[$];
    t_lcd_pins   due_pins;
    t_lcd_pins   seen_pins;
    int          fault_count = 0;
    int          feed_gap_max = 4;
    int          sink_gap_max = 4;
    int          sink_hold = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("char_lcd_nibble_write_sequencer_tb: errors");
        $finish;
    end

    function automatic int unsigned en_len();
        return (ew_reg != 8'd0) ? int'(ew_reg) : 1;
    endfunction

    function automatic int unsigned wait_len(input int unsigned us);
        longint unsigned n;
        n = longint'(us) * longint'(tpu_reg);
        if (n > WAIT_MAX) begin
            n = WAIT_MAX;
        end
        if (n == 0) begin
            n = 1;
        end
        return int'(n);
    endfunction

    task automatic go_idle();
        init_idx = 0;
        seq_state = SEQ_IDLE;
        wait_left = 0;
    endtask

    task automatic start_wait(input int unsigned us);
        pin_e = 1'b0;
        seq_state = SEQ_WAIT;
        wait_left = wait_len(us);
    endtask

    task automatic start_byte(input logic rs, input logic [7:0] value, input logic longw);
        held_byte = value;
        long_pending = longw;
        pin_rs = rs;
        pin_e = 1'b1;
        pin_bus = value[7:4];
        seq_state = SEQ_HI_ON;
        wait_left = en_len();
    endtask

    task automatic start_nibble(input logic [3:0] nib);
        held_byte = {4'h0, nib};
        long_pending = 1'b0;
        pin_rs = 1'b0;
        pin_e = 1'b1;
        pin_bus = nib;
        seq_state = SEQ_LO_ON;
        wait_left = en_len();
    endtask

    task automatic start_unit(input int step);
        case (step)
            STEP_POWER_WAIT: start_wait(WAIT_POWER_UP_US);
            STEP_WAKE_1: start_nibble(NIBBLE_WAKE);
            STEP_WAKE_2: start_nibble(NIBBLE_WAKE);
            STEP_FOUR_BIT: start_nibble(NIBBLE_4BIT);
            STEP_FUNC_SET: start_byte(1'b0, LCD_FUNC_4BIT, 1'b0);
            STEP_DISPLAY_OFF: start_byte(1'b0, LCD_DISPLAY_OFF, 1'b0);
            STEP_CLEAR: start_byte(1'b0, LCD_CLEAR, 1'b1);
            STEP_ENTRY: start_byte(1'b0, LCD_ENTRY_MODE, 1'b0);
            STEP_DISPLAY_ON: start_byte(1'b0, LCD_DISPLAY_ON, 1'b0);
            default: go_idle();
        endcase
    endtask

    task automatic finish_unit();
        case (seq_state)
            SEQ_HI_ON: begin
                pin_e = 1'b0;
                seq_state = SEQ_HI_OFF;
                wait_left = en_len();
            end
            SEQ_HI_OFF: begin
                pin_e = 1'b1;
                pin_bus = held_byte[3:0];
                seq_state = SEQ_LO_ON;
                wait_left = en_len();
            end
            SEQ_LO_ON: begin
                pin_e = 1'b0;
                seq_state = SEQ_LO_OFF;
                wait_left = en_len();
            end
            SEQ_LO_OFF: begin
                if (init_idx == STEP_WAKE_1) begin
                    start_wait(WAIT_WAKE_FIRST_US);
                end else if (init_idx == STEP_WAKE_2 || init_idx == STEP_FOUR_BIT) begin
                    start_wait(WAIT_WAKE_NEXT_US);
                end else begin
                    start_wait(WAIT_BYTE_US);
                end
            end
            SEQ_WAIT: begin
                if (long_pending) begin
                    long_pending = 1'b0;
                    start_wait(WAIT_LONG_US);
                end else if (init_idx >= STEP_POWER_WAIT && init_idx < STEP_DISPLAY_ON) begin
                    init_idx++;
                    start_unit(init_idx);
                end else begin
                    go_idle();
                end
            end
            default: go_idle();
        endcase
    endtask

    // Advances the pin predictor by one accepted item and queues the pins it should produce.
    task automatic predict_tick(input logic [2:0] op, input logic [7:0] value);
        t_lcd_pins due;
        logic      is_request;
        logic      was_busy;
        is_request = (op >= clnws_pkg::OP_CMD) && (op <= clnws_pkg::OP_HOME);
        was_busy = (seq_state != SEQ_IDLE);
        if (!was_busy && is_request) begin
            init_idx = 0;
            case (op)
                clnws_pkg::OP_CMD: start_byte(1'b0, value, 1'b0);
                clnws_pkg::OP_DATA: start_byte(1'b1, value, 1'b0);
                clnws_pkg::OP_INIT: begin
                    init_idx = STEP_POWER_WAIT;
                    start_unit(STEP_POWER_WAIT);
                end
                clnws_pkg::OP_CLEAR: start_byte(1'b0, LCD_CLEAR, 1'b1);
                default: start_byte(1'b0, LCD_HOME, 1'b1);
            endcase
        end
        due.rs = pin_rs;
        due.e = pin_e;
        due.bus = pin_bus;
        due.busy = (seq_state != SEQ_IDLE);
        due.rejected = was_busy && is_request;
        expected_pins.push_back(due);
        if (seq_state != SEQ_IDLE) begin
            if (wait_left != 0) begin
                wait_left--;
            end
            if (wait_left == 0) begin
                finish_unit();
            end
        end
    endtask

    task automatic compare_field(input string label, input logic [3:0] want, input logic [3:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
            fault_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_pins.size() == 0) begin
                $display("%0t ns: item expected none, got %h", $time, o_m_tdata);
                fault_count++;
            end else begin
                due_pins = expected_pins.pop_front();
                seen_pins = o_m_tdata;
                compare_field("reg_select", 4'(due_pins.rs), 4'(seen_pins.rs));
                compare_field("enable", 4'(due_pins.e), 4'(seen_pins.e));
                compare_field("bus_nibble", due_pins.bus, seen_pins.bus);
                compare_field("busy_res", 4'(due_pins.busy), 4'(seen_pins.busy));
                compare_field("rejected", 4'(due_pins.rejected), 4'(seen_pins.rejected));
            end
        end
    end

    initial begin : sink
        int stall;
        i_m_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (sink_hold > 0) begin
                stall = sink_hold;
                sink_hold = 0;
            end else begin
                stall = $urandom_range(0, sink_gap_max);
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
        end
    end

    task automatic send_item(input logic [2:0] op, input logic [7:0] value);
        int gap;
        gap = $urandom_range(0, feed_gap_max);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tdata <= {5'd0, value, op};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        predict_tick(op, value);
    endtask

    // Mostly well-formed traffic: requests when idle, ticks with some rejected requests when busy.
    task automatic send_random_tick();
        int r;
        r = $urandom_range(0, 9);
        if (seq_state == SEQ_IDLE) begin
            if (r == 0) begin
                send_item(($urandom_range(0, 2) == 0) ? clnws_pkg::OP_TICK :
                          3'($urandom_range(OP_SPARE_6, OP_SPARE_7)), 8'($urandom));
            end else if (tpu_reg == 7'd0) begin
                send_item(3'($urandom_range(clnws_pkg::OP_CMD, clnws_pkg::OP_HOME)),
                          8'($urandom));
            end else begin
                send_item(3'($urandom_range(clnws_pkg::OP_CMD, clnws_pkg::OP_DATA)),
                          8'($urandom));
            end
        end else begin
            if (r < 2) begin
                send_item(3'($urandom_range(clnws_pkg::OP_CMD, clnws_pkg::OP_HOME)),
                          8'($urandom));
            end else if (r == 2) begin
                send_item(3'($urandom_range(OP_SPARE_6, OP_SPARE_7)), 8'($urandom));
            end else begin
                send_item(clnws_pkg::OP_TICK, 8'($urandom));
            end
        end
    endtask

    task automatic run_to_idle();
        while (seq_state != SEQ_IDLE) begin
            send_random_tick();
        end
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (expected_pins.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
        i_cfg_index <= index;
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == clnws_pkg::CFG_TICKS_PER_US) begin
            tpu_reg = value[6:0];
        end else if (index == clnws_pkg::CFG_ENABLE_WIDTH) begin
            ew_reg = value;
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reconfigure(input logic [7:0] tpu_val, input logic [7:0] ew_val);
        run_to_idle();
        drain_results();
        write_reg(clnws_pkg::CFG_TICKS_PER_US, tpu_val);
        write_reg(clnws_pkg::CFG_ENABLE_WIDTH, ew_val);
    endtask

    task automatic test_idle_noise();
        send_item(clnws_pkg::OP_TICK, 8'h00);
        send_item(clnws_pkg::OP_TICK, 8'hFF);
        send_item(OP_SPARE_6, 8'hA5);
        send_item(OP_SPARE_7, 8'h5A);
    endtask

    task automatic test_power_up_init();
        drain_results();
        write_reg(clnws_pkg::CFG_TICKS_PER_US, 8'd0);
        feed_gap_max = 0;
        sink_gap_max = 0;
        send_item(clnws_pkg::OP_INIT, 8'h00);
        run_to_idle();
        feed_gap_max = 4;
        sink_gap_max = 4;
    endtask

    task automatic test_byte_writes();
        reconfigure(8'd0, 8'd0);
        send_item(clnws_pkg::OP_CMD, 8'h00);
        run_to_idle();
        send_item(clnws_pkg::OP_DATA, 8'hFF);
        run_to_idle();
        send_item(clnws_pkg::OP_CMD, 8'h81);
        run_to_idle();
        send_item(clnws_pkg::OP_DATA, 8'h7E);
        run_to_idle();
        send_item(clnws_pkg::OP_INIT, 8'hFF);
        run_to_idle();
    endtask

    task automatic test_clear_home();
        feed_gap_max = 0;
        sink_gap_max = 0;
        reconfigure(8'd0, 8'd2);
        send_item(clnws_pkg::OP_CLEAR, 8'h00);
        run_to_idle();
        send_item(clnws_pkg::OP_HOME, 8'hFF);
        run_to_idle();
        feed_gap_max = 4;
        sink_gap_max = 4;
        reconfigure(8'd0, 8'd3);
        send_item(clnws_pkg::OP_CLEAR, 8'h55);
        run_to_idle();
        send_item(clnws_pkg::OP_HOME, 8'hAA);
        run_to_idle();
    endtask

    // The top bit of the ticks_per_us write is dropped, leaving zero.
    task automatic test_extreme_timing();
        feed_gap_max = 0;
        sink_gap_max = 0;
        reconfigure(8'h80, 8'd255);
        send_item(clnws_pkg::OP_DATA, 8'hC3);
        run_to_idle();
        feed_gap_max = 4;
        sink_gap_max = 4;
    endtask

    task automatic test_unused_register();
        reconfigure(8'd0, 8'd1);
        write_reg(CFG_UNUSED_2, 8'hFF);
        write_reg(CFG_UNUSED_3, 8'hFF);
        send_item(clnws_pkg::OP_CMD, 8'h3C);
        run_to_idle();
    endtask

    task automatic test_backpressure();
        reconfigure(8'd0, 8'd1);
        feed_gap_max = 0;
        sink_gap_max = 0;
        sink_hold = 48;
        repeat (40) send_random_tick();
        drain_results();
        feed_gap_max = 4;
        sink_gap_max = 4;
    endtask

    task automatic test_random_traffic();
        int block;
        int count;
        int tpu_pick;
        for (block = 0; block < RANDOM_BLOCKS; block++) begin
            tpu_pick = $urandom_range(0, 3);
            reconfigure((tpu_pick < 2) ? 8'd0 : 8'(tpu_pick - 1),
                        ($urandom_range(0, 4) == 0) ? 8'($urandom_range(4, 40)) :
                                                      8'($urandom_range(0, 3)));
            feed_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
            sink_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 4;
            for (count = 0; count < RANDOM_BLOCK_ITEMS; count++) begin
                send_random_tick();
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_noise();
        test_power_up_init();
        test_byte_writes();
        test_clear_home();
        test_extreme_timing();
        test_unused_register();
        test_backpressure();
        test_random_traffic();

        drain_results();
        if (fault_count == 0) begin
            $display("char_lcd_nibble_write_sequencer_tb: clean");
        end else begin
            $display("char_lcd_nibble_write_sequencer_tb: errors");
        end
        $finish;
    end

endmodule
